// ===== hw/rtl/fpa_pkg.sv =====
// Shared constants, codes and types of the fixed partition allocator.
package fpa_pkg;

  localparam int NUM_PARTITIONS = 10;
  localparam int TABLE_MAX      = 16;
  localparam int IDX_W          = 4;
  localparam int SIZE_W         = 10;
  localparam int PID_W          = 16;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic [SIZE_W-1:0] PRESET_SIZE [TABLE_MAX] = '{
    10'd100, 10'd500, 10'd200, 10'd300, 10'd600, 10'd150, 10'd400, 10'd250,
    10'd350, 10'd120, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0
  };

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } cand_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [1:0]        pol;
    logic [SIZE_W-1:0] req;
    logic [PID_W-1:0]  rel;
    logic [IDX_W-1:0]  start;
    cand_t             main_c;
    cand_t             wrap_c;
  } token_t;

  typedef struct packed {
    logic             valid;
    logic             set;
    logic [IDX_W-1:0] idx;
    logic [PID_W-1:0] owner;
  } commit_t;

endpackage

// ===== hw/rtl/fpa_in_if.sv =====
// Request channel of the fixed partition allocator.
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [9:0]  request_size;
  logic [1:0]  fit_policy;
  logic [15:0] release_id;

  modport source (output valid, output operation, output request_size,
                  output fit_policy, output release_id, input ready);
  modport sink   (input valid, input operation, input request_size,
                  input fit_policy, input release_id, output ready);
endinterface

// ===== hw/rtl/fpa_out_if.sv =====
// Result channel of the fixed partition allocator.
interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [3:0]  partition_index;
  logic [15:0] process_id;
  logic [9:0]  partition_size;

  modport source (output valid, output success, output partition_index,
                  output process_id, output partition_size, input ready);
  modport sink   (input valid, input success, input partition_index,
                  input process_id, input partition_size, output ready);
endinterface

// ===== hw/rtl/fpa_cell.sv =====
// One partition cell: holds busy and owner, folds its entry into the passing search token.
module fpa_cell
  import fpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  token_t           tok_i,
  input  commit_t          commit_i,
  output token_t           tok_o
);

  logic              busy_r;
  logic [PID_W-1:0]  owner_r;
  token_t            tok_r;
  token_t            tok_nxt;
  logic [SIZE_W-1:0] size;
  logic              elig;
  logic              take_main;
  logic              take_wrap;

  assign size = PRESET_SIZE[cell_idx];

  always_comb begin
    if (tok_i.op == OP_RELEASE) begin
      elig = busy_r && (owner_r == tok_i.rel);
    end else begin
      elig = !busy_r && (size >= tok_i.req);
    end

    take_main = 1'b0;
    take_wrap = 1'b0;
    if (elig) begin
      if (tok_i.op == OP_RELEASE) begin
        take_main = !tok_i.main_c.hit;
      end else begin
        case (tok_i.pol)
          POL_FIRST: take_main = !tok_i.main_c.hit;
          POL_BEST:  take_main = !tok_i.main_c.hit || (size < tok_i.main_c.size);
          POL_WORST: take_main = !tok_i.main_c.hit || (size > tok_i.main_c.size);
          POL_NEXT: begin
            // entries below the pointer only count after the wrap
            if (cell_idx >= tok_i.start) begin
              take_main = !tok_i.main_c.hit;
            end else begin
              take_wrap = !tok_i.wrap_c.hit;
            end
          end
          default: take_main = 1'b0;
        endcase
      end
    end

    tok_nxt = tok_i;
    if (take_main) begin
      tok_nxt.main_c.hit  = 1'b1;
      tok_nxt.main_c.idx  = cell_idx;
      tok_nxt.main_c.size = size;
    end
    if (take_wrap) begin
      tok_nxt.wrap_c.hit  = 1'b1;
      tok_nxt.wrap_c.idx  = cell_idx;
      tok_nxt.wrap_c.size = size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (commit_i.valid && (commit_i.idx == cell_idx)) begin
      busy_r <= commit_i.set;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_i.valid && commit_i.set && (commit_i.idx == cell_idx)) begin
      owner_r <= commit_i.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== hw/rtl/fixed_partition_allocator.sv =====
// Fixed partition allocator: a row of partition cells scanned by a traveling token.
// A request beat is registered into the token head, the token passes one cell per cycle through
//   the registered cells, and the result is registered into the output registers; the next
//   request is taken the cycle after the result beat, later by every cycle the result waits.
// Reset: rst_n synchronous active low; all partitions free, next-fit pointer 0, id counter 1.
module fixed_partition_allocator
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

  token_t            tok [NUM_PARTITIONS+1];
  token_t            tok0_r;
  logic              scan_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [PID_W-1:0]  ctr_r;
  logic              out_valid_r;
  logic              out_success_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic              in_beat;
  logic              out_beat;
  cand_t             pick;
  commit_t           commit;
  token_t            tail;
  logic [NUM_PARTITIONS:0] tok_valids;

  assign in_ch.ready = !scan_r && !out_valid_r;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_beat    = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.valid <= 1'b0;
    end else begin
      tok0_r.valid       <= in_beat;
      tok0_r.op          <= in_ch.operation;
      tok0_r.pol         <= in_ch.fit_policy;
      tok0_r.req         <= in_ch.request_size;
      tok0_r.rel         <= in_ch.release_id;
      tok0_r.start       <= ptr_r;
      tok0_r.main_c      <= '0;
      tok0_r.wrap_c      <= '0;
    end
  end

  assign tok[0] = tok0_r;

  for (genvar i = 0; i < NUM_PARTITIONS; i++) begin : g_cell
    fpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_i    (tok[i]),
      .commit_i (commit),
      .tok_o    (tok[i+1])
    );
  end

  for (genvar j = 0; j <= NUM_PARTITIONS; j++) begin : g_valids
    assign tok_valids[j] = tok[j].valid;
  end

  assign tail = tok[NUM_PARTITIONS];

  always_comb begin
    // wrapped hit serves next fit only when nothing was found from the pointer up
    if ((tail.op == OP_ALLOC) && (tail.pol == POL_NEXT) && !tail.main_c.hit) begin
      pick = tail.wrap_c;
    end else begin
      pick = tail.main_c;
    end
    commit.valid = tail.valid && pick.hit;
    commit.set   = (tail.op == OP_ALLOC);
    commit.idx   = pick.idx;
    commit.owner = ctr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      ctr_r       <= PID_W'(1);
    end else begin
      if (in_beat) begin
        scan_r <= 1'b1;
      end else if (tail.valid) begin
        scan_r <= 1'b0;
      end
      if (tail.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_beat) begin
        out_valid_r <= 1'b0;
      end
      if (commit.valid && commit.set) begin
        ctr_r <= ctr_r + PID_W'(1);
        if (tail.pol == POL_NEXT) begin
          if (pick.idx == IDX_W'(NUM_PARTITIONS - 1)) begin
            ptr_r <= '0;
          end else begin
            ptr_r <= pick.idx + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      out_success_r <= pick.hit;
      out_index_r   <= pick.hit ? pick.idx : '0;
      out_size_r    <= pick.hit ? pick.size : '0;
      if (!pick.hit) begin
        out_pid_r <= '0;
      end else if (tail.op == OP_ALLOC) begin
        out_pid_r <= ctr_r;
      end else begin
        out_pid_r <= tail.rel;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.success         = out_success_r;
  assign out_ch.partition_index = out_index_r;
  assign out_ch.process_id      = out_pid_r;
  assign out_ch.partition_size  = out_size_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valids))
    else $error("more than one search token in the cell row");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> scan_r)
    else $error("token left the cell row with no scan in flight");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < IDX_W'(NUM_PARTITIONS))
    else $error("next-fit pointer out of range");

  a_beat_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (scan_r && tok0_r.valid))
    else $error("request beat did not start a scan");

endmodule
